@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PLTI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define PLTI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/plti_pkg.sv @@
// ---------------------------------------------------------------------------
// Interpolator package
// Status codes, command and status structures shared by controller and datapath.
// ---------------------------------------------------------------------------
package plti_pkg;

    localparam int DATA_W = 32;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 11;

    localparam logic [ST_W-1:0] ST_WRITE  = 3'd0;
    localparam logic [ST_W-1:0] ST_INTERP = 3'd1;
    localparam logic [ST_W-1:0] ST_EXTRAP = 3'd2;
    localparam logic [ST_W-1:0] ST_BELOW  = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO   = 3'd4;

    typedef enum logic [2:0] {
        A_HOLD, A_ZERO, A_LAST, A_NODEA, A_ONE, A_INC, A_DEC
    } addr_op_t;

    typedef enum logic [1:0] {
        RK_ZERO, RK_RDY, RK_LINE
    } res_kind_t;

    typedef struct packed {
        logic            wr;
        logic            start;
        addr_op_t        addr_op;
        logic            cap1;
        logic            cap0;
        logic            mul_start;
        logic            mul_step;
        logic            div_start;
        logic            div_step;
        logic            set_res;
        res_kind_t       res_kind;
        logic [ST_W-1:0] res_st;
        logic            out_load;
    } cmd_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
        logic scan_end;
        logic dx_zero;
        logic mul_done;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

endpackage

@@ hdl/plti_ctrl.sv @@
// ---------------------------------------------------------------------------
// Interpolator controller
// Sequences table reads, the interval scan, multiply, divide and result hand-off.
// ---------------------------------------------------------------------------
module plti_ctrl
    import plti_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic func,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_L0   = 13'b0000000000010,
        S_C0   = 13'b0000000000100,
        S_LN   = 13'b0000000001000,
        S_CN   = 13'b0000000010000,
        S_LS   = 13'b0000000100000,
        S_CS   = 13'b0000001000000,
        S_LP   = 13'b0000010000000,
        S_CP   = 13'b0000100000000,
        S_CHK  = 13'b0001000000000,
        S_MUL  = 13'b0010000000000,
        S_DIV  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ext_reg, ext_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ext_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ext_reg   <= ext_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ext_next   = ext_reg;
        cmd        = '0;
        cmd.addr_op  = A_HOLD;
        cmd.res_kind = RK_ZERO;
        cmd.res_st   = ST_WRITE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!func) begin
                        cmd.wr      = 1'b1;
                        cmd.set_res = 1'b1;
                        state_next  = S_DONE;
                    end else begin
                        cmd.start   = 1'b1;
                        cmd.addr_op = A_ZERO;
                        state_next  = S_L0;
                    end
                end
            end
            S_L0: state_next = S_C0;
            S_C0: begin
                if (sts.lt) begin
                    cmd.set_res = 1'b1;
                    cmd.res_st  = ST_BELOW;
                    state_next  = S_DONE;
                end else if (sts.eq) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RK_RDY;
                    cmd.res_st   = ST_INTERP;
                    state_next   = S_DONE;
                end else begin
                    cmd.addr_op = A_LAST;
                    state_next  = S_LN;
                end
            end
            S_LN: state_next = S_CN;
            S_CN: begin
                if (sts.gt) begin
                    cmd.cap1    = 1'b1;
                    cmd.addr_op = A_NODEA;
                    ext_next    = 1'b1;
                    state_next  = S_LP;
                end else if (sts.eq) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RK_RDY;
                    cmd.res_st   = ST_INTERP;
                    state_next   = S_DONE;
                end else begin
                    cmd.addr_op = A_ONE;
                    state_next  = S_LS;
                end
            end
            S_LS: state_next = S_CS;
            S_CS: begin
                if (sts.lt || sts.scan_end) begin
                    cmd.cap1    = 1'b1;
                    cmd.addr_op = A_DEC;
                    ext_next    = 1'b0;
                    state_next  = S_LP;
                end else begin
                    cmd.addr_op = A_INC;
                    state_next  = S_LS;
                end
            end
            S_LP: state_next = S_CP;
            S_CP: begin
                cmd.cap0   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (sts.dx_zero) begin
                    cmd.set_res = 1'b1;
                    cmd.res_st  = ST_ZERO;
                    state_next  = S_DONE;
                end else begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL: begin
                if (sts.mul_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RK_LINE;
                    cmd.res_st   = ext_reg ? ST_EXTRAP : ST_INTERP;
                    state_next   = S_DONE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ hdl/plti_dp.sv @@
// ---------------------------------------------------------------------------
// Interpolator datapath
// Breakpoint memories, scan address, serial multiplier and divider, output stage.
// ---------------------------------------------------------------------------
module plti_dp
    import plti_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CNT_W-1:0]         cfg_wdata,
    input  logic [9:0]               entry_index,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] y_value,
    input  logic signed [DATA_W-1:0] query_value,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic                     m_tready,
    output logic                     m_valid,
    output logic [DATA_W-1:0]        m_result,
    output logic [ST_W-1:0]          m_status,
    output logic                     m_sat
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int NW  = (CW > CNT_W) ? CW : CNT_W;
    localparam int IW  = (AW > 10) ? AW : 10;

    logic [DATA_W-1:0] x_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] y_mem [TABLE_DEPTH];

    logic [CNT_W-1:0]         count_reg;
    logic [NW-1:0]            n_reg, n_next;
    logic [AW-1:0]            addr_reg, addr_next;
    logic signed [DATA_W-1:0] v_reg, rd_x_reg, rd_y_reg;
    logic signed [DATA_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [64:0]              ma_reg, prod_reg, quo_reg;
    logic [32:0]              mb_reg, rem_reg, dmag_reg;
    logic [5:0]               mcnt_reg;
    logic [6:0]               dcnt_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        res_val_reg, res_val_next;
    logic [ST_W-1:0]          res_st_reg;
    logic                     res_sat_reg, res_sat_next;
    logic                     m_valid_reg;
    logic [DATA_W-1:0]        m_result_reg;
    logic [ST_W-1:0]          m_status_reg;
    logic                     m_sat_reg;

    logic [NW-1:0]        cnt_ext;
    logic [AW-1:0]        last_idx, node_a;
    logic [IW-1:0]        widx;
    logic                 in_range;
    logic signed [32:0]   dx, dy, dv;
    logic [33:0]          trial;
    logic                 ge;
    logic                 q_neg, q_big;
    logic signed [35:0]   line_sum;

    assign cnt_ext  = NW'(count_reg);
    assign n_next   = (cnt_ext < NW'(2)) ? NW'(2) :
                      (cnt_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : cnt_ext;
    assign last_idx = AW'(n_reg - NW'(1));
    assign node_a   = (n_reg > NW'(2)) ? AW'(n_reg - NW'(3)) : AW'(n_reg - NW'(2));
    assign widx     = IW'(entry_index);
    assign in_range = (32'(entry_index) < 32'(TABLE_DEPTH));

    always_comb begin
        unique case (cmd.addr_op)
            A_HOLD:  addr_next = addr_reg;
            A_ZERO:  addr_next = '0;
            A_LAST:  addr_next = last_idx;
            A_NODEA: addr_next = node_a;
            A_ONE:   addr_next = AW'(1);
            A_INC:   addr_next = addr_reg + AW'(1);
            A_DEC:   addr_next = addr_reg - AW'(1);
            default: addr_next = addr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr && in_range) begin
            x_mem[widx[AW-1:0]] <= x_value;
            y_mem[widx[AW-1:0]] <= y_value;
        end
        rd_x_reg <= x_mem[addr_reg];
        rd_y_reg <= y_mem[addr_reg];
    end

    assign dx = 33'(x1_reg) - 33'(x0_reg);
    assign dy = 33'(y1_reg) - 33'(y0_reg);
    assign dv = 33'(v_reg) - 33'(x0_reg);

    assign trial = {rem_reg, quo_reg[64]};
    assign ge    = (trial >= {1'b0, dmag_reg});

    assign q_neg    = neg_reg && (quo_reg != '0);
    assign q_big    = (quo_reg > 65'h2_0000_0000);
    assign line_sum = q_neg ? (36'(y0_reg) - $signed({1'b0, quo_reg[34:0]}))
                            : (36'(y0_reg) + $signed({1'b0, quo_reg[34:0]}));

    always_comb begin
        res_val_next = '0;
        res_sat_next = 1'b0;
        unique case (cmd.res_kind)
            RK_ZERO: res_val_next = '0;
            RK_RDY:  res_val_next = rd_y_reg;
            RK_LINE: begin
                if (q_big) begin
                    res_val_next = q_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    res_sat_next = 1'b1;
                end else if (line_sum > 36'sd2147483647) begin
                    res_val_next = 32'h7FFF_FFFF;
                    res_sat_next = 1'b1;
                end else if (line_sum < -36'sd2147483648) begin
                    res_val_next = 32'h8000_0000;
                    res_sat_next = 1'b1;
                end else begin
                    res_val_next = line_sum[31:0];
                end
            end
            default: res_val_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            v_reg <= query_value;
            n_reg <= n_next;
        end
        addr_reg <= addr_next;
        if (cmd.cap1) begin
            x1_reg <= rd_x_reg;
            y1_reg <= rd_y_reg;
        end
        if (cmd.cap0) begin
            x0_reg <= rd_x_reg;
            y0_reg <= rd_y_reg;
        end
        if (cmd.mul_start) begin
            ma_reg   <= 65'(mag33(dy));
            mb_reg   <= mag33(dv);
            dmag_reg <= mag33(dx);
            neg_reg  <= (dy[32] ^ dv[32]) ^ dx[32];
            prod_reg <= '0;
            mcnt_reg <= '0;
        end else if (cmd.mul_step) begin
            if (mb_reg[0]) begin
                prod_reg <= prod_reg + ma_reg;
            end
            ma_reg   <= {ma_reg[63:0], 1'b0};
            mb_reg   <= {1'b0, mb_reg[32:1]};
            mcnt_reg <= mcnt_reg + 6'd1;
        end
        if (cmd.div_start) begin
            quo_reg  <= prod_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= ge ? 33'(trial - {1'b0, dmag_reg}) : trial[32:0];
            quo_reg  <= {quo_reg[63:0], ge};
            dcnt_reg <= dcnt_reg + 7'd1;
        end
        if (cmd.set_res) begin
            res_val_reg <= res_val_next;
            res_st_reg  <= cmd.res_st;
            res_sat_reg <= res_sat_next;
        end
        if (cmd.out_load) begin
            m_result_reg <= res_val_reg;
            m_status_reg <= res_st_reg;
            m_sat_reg    <= res_sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= CNT_W'(2);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.lt       = (v_reg < rd_x_reg);
    assign sts.eq       = (v_reg == rd_x_reg);
    assign sts.gt       = (v_reg > rd_x_reg);
    assign sts.scan_end = (addr_reg == last_idx);
    assign sts.dx_zero  = (dx == '0);
    assign sts.mul_done = (mcnt_reg == 6'd33);
    assign sts.div_done = (dcnt_reg == 7'd65);
    assign sts.out_free = !m_valid_reg || m_tready;

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign m_status = m_status_reg;
    assign m_sat    = m_sat_reg;

endmodule

@@ hdl/piecewise_linear_table_interpolator.sv @@
// A write item stores one breakpoint, and its result item passes through the result register
// and the output register. A query is compared first with the first x and answered there if
// below or equal to it, then with the last x and answered there if equal to it. A query above
// the last x is extrapolated through the multiply and divide. An interior query first scans
// the breakpoints, from one breakpoint up to one fewer than the breakpoints in use. A zero-width
// line skips the multiply and divide, above the last x or inside the table. Query handling uses
// the linear interval scan, which makes one registered memory read for each entry, the 33-step
// shift-add multiplier and the 65-step restoring divider; a stalled output stream holds the
// result. One item is processed at a time, and the next item is accepted while a result waits
// at the output.
// ---------------------------------------------------------------------------
// Piecewise-linear table interpolator
// Stores Q16.16 breakpoints and interpolates or extrapolates query values.
// ---------------------------------------------------------------------------
module piecewise_linear_table_interpolator
    import plti_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [10:0]      cfg_wdata,     // entry_count
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [111:0]     s_tdata,       // entry_index, x_value, y_value, query_value
    input  logic             s_tuser,       // func
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata        // result_value, status, saturated
);

    cmd_t              cmd;
    sts_t              sts;
    logic [DATA_W-1:0] m_result;
    logic [ST_W-1:0]   m_status;
    logic              m_sat;
    logic              s_tready_int;

    plti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .s_tready (s_tready_int),
        .sts      (sts),
        .cmd      (cmd)
    );

    plti_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .entry_index (s_tdata[9:0]),
        .x_value     (s_tdata[41:10]),
        .y_value     (s_tdata[73:42]),
        .query_value (s_tdata[105:74]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_valid     (m_tvalid),
        .m_result    (m_result),
        .m_status    (m_status),
        .m_sat       (m_sat)
    );

    assign s_tready = s_tready_int;
    assign m_tdata  = {4'b0, m_sat, m_status, m_result};

endmodule

@@ hdl/plti_checker.sv @@
// ---------------------------------------------------------------------------
// Interpolator port checker
// Checks the result stream and the one-item-at-a-time input behaviour.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module plti_checker
    import plti_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);

    `PLTI_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "Result item changed while stalled.")
    `PLTI_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready,
        "Input item accepted while another is in progress.")
    `PLTI_ASSERT_IMP(a_sat_kind, m_tvalid && m_tdata[35],
        m_tdata[34:32] == ST_INTERP || m_tdata[34:32] == ST_EXTRAP,
        "Saturation flagged on a result with no computed value.")
    `PLTI_ASSERT_IMP(a_zero_res, m_tvalid && (m_tdata[34:32] == ST_WRITE ||
        m_tdata[34:32] == ST_BELOW || m_tdata[34:32] == ST_ZERO),
        m_tdata[31:0] == 32'd0 && !m_tdata[35],
        "Write or error result item carries a non-zero value.")

endmodule

bind piecewise_linear_table_interpolator plti_checker u_plti_checker (.*);

@@ sim/piecewise_linear_table_interpolator_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Piecewise-linear table interpolator testbench
// Loads breakpoint tables of many sizes, sorted and unsorted, and sends
// queries below, on, inside and above them. Results are compared with directed
// expectations or a local Q16.16 line evaluator, under varied idling on both streams.
// ---------------------------------------------------------------------------
module piecewise_linear_table_interpolator_test;
    import plti_pkg::*;

    localparam int  DEPTH       = 1024;
    localparam int  WATCH_LIMIT = 40000;
    localparam bit  FUNC_WRITE  = 1'b0;
    localparam bit  FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic            sat;
        logic [ST_W-1:0] st;
        logic [31:0]     value;
    } outcome_t;

    typedef struct {
        bit              func;
        logic [9:0]      idx;
        logic [31:0]     x;
        logic [31:0]     y;
        logic [31:0]     q;
        bit              typed;
        logic [31:0]     value;
        logic [ST_W-1:0] st;
    } row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_we = 1'b0;
    logic [10:0]   cfg_wdata = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [39:0]   m_tdata;

    logic [31:0]   bp_x [DEPTH];
    logic [31:0]   bp_y [DEPTH];
    logic [10:0]   count_reg;
    outcome_t      pending [$];
    int            errors = 0;
    int            sent = 0;
    int            status_seen [5];
    int            send_idle = 0;
    int            recv_stall = 0;
    int            quiet = 0;

    always #4 aclk = ~aclk;

    piecewise_linear_table_interpolator dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic outcome_t line_value(longint x0, longint y0, longint x1, longint y1,
                                            longint v, logic [ST_W-1:0] ok);
        outcome_t        o;
        longint          dx, dy, dv, r;
        longint unsigned q;
        bit              neg;
        dx = x1 - x0;
        dy = y1 - y0;
        dv = v - x0;
        o = '{value: '0, st: ST_ZERO, sat: 1'b0};
        if (dx == 0)
            return o;
        o.st = ok;
        neg = ((dy < 0) != (dv < 0)) != (dx < 0);
        q = (magnitude(dy) * magnitude(dv)) / magnitude(dx);
        if (q == 0)
            neg = 1'b0;
        if (q > 64'h2_0000_0000) begin
            o.value = neg ? 32'h8000_0000 : 32'h7fff_ffff;
            o.sat = 1'b1;
            return o;
        end
        r = y0 + (neg ? -longint'(q) : longint'(q));
        if (r > 64'sh7fff_ffff) begin
            r = 64'sh7fff_ffff;
            o.sat = 1'b1;
        end
        if (r < -64'sh8000_0000) begin
            r = -64'sh8000_0000;
            o.sat = 1'b1;
        end
        o.value = r[31:0];
        return o;
    endfunction

    function automatic outcome_t interpolate(bit func, logic [9:0] idx, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] qv);
        outcome_t o;
        int       n, i, a;
        longint   v;
        o = '{value: '0, st: ST_WRITE, sat: 1'b0};
        if (func == FUNC_WRITE) begin
            bp_x[idx] = x;
            bp_y[idx] = y;
            return o;
        end
        n = count_reg < 2 ? 2 : (count_reg > DEPTH ? DEPTH : count_reg);
        v = longint'($signed(qv));
        if (v < longint'($signed(bp_x[0]))) begin
            o.st = ST_BELOW;
        end else if (v == longint'($signed(bp_x[0]))) begin
            o.value = bp_y[0];
            o.st = ST_INTERP;
        end else if (v > longint'($signed(bp_x[n-1]))) begin
            a = n > 2 ? n - 3 : n - 2;
            o = line_value($signed(bp_x[a]), $signed(bp_y[a]), $signed(bp_x[n-1]),
                           $signed(bp_y[n-1]), v, ST_EXTRAP);
        end else if (v == longint'($signed(bp_x[n-1]))) begin
            o.value = bp_y[n-1];
            o.st = ST_INTERP;
        end else begin
            i = 0;
            while (i < n - 2 && !(v < longint'($signed(bp_x[i+1]))))
                i++;
            o = line_value($signed(bp_x[i]), $signed(bp_y[i]), $signed(bp_x[i+1]),
                           $signed(bp_y[i+1]), v, ST_INTERP);
        end
        return o;
    endfunction

    task automatic send(bit func, logic [9:0] idx, logic [31:0] x, logic [31:0] y,
                        logic [31:0] qv, bit typed, outcome_t typed_out);
        outcome_t o;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'b0, qv, y, x, idx};
        do @(posedge aclk); while (!s_tready);
        o = interpolate(func, idx, x, y, qv);
        pending.push_back(typed ? typed_out : o);
        sent++;
        if (func == FUNC_QUERY)
            status_seen[o.st]++;
    endtask

    task automatic send_plain(bit func, logic [9:0] idx, logic [31:0] x, logic [31:0] y,
                              logic [31:0] qv);
        send(func, idx, x, y, qv, 1'b0, '0);
    endtask

    task automatic write_count(logic [10:0] value);
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        count_reg = value;
    endtask

    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[35:0];
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.value !== want.value || got.st !== want.st || got.sat !== want.sat) begin
                    $display("%0t: expected value %h status %0d sat %0d, actual %h %0d %0d",
                             $time, want.value, want.st, want.sat, got.value, got.st, got.sat);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall);
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            quiet <= quiet + 1;
            if (quiet >= WATCH_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end else begin
            quiet <= 0;
        end
    end

    function automatic logic [31:0] pick_query(int n);
        int k;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(9))
            0: return $urandom;
            1: return bp_x[k];
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return bp_x[n-1] + ($urandom >> $urandom_range(0, 31));
            default: return bp_x[k] + (int'($urandom) >>> $urandom_range(4, 31));
        endcase
    endfunction

    task automatic load_table(int n, bit sorted);
        int xs [$];
        int spread;
        spread = $urandom_range(0, 30);
        xs = {};
        for (int i = 0; i < n; i++)
            xs.push_back(int'($urandom) >>> spread);
        if (sorted)
            xs.sort();
        for (int i = 0; i < n; i++) begin
            send_plain(FUNC_WRITE, i[9:0], xs[i], int'($urandom) >>> $urandom_range(0, 31), $urandom);
            if ($urandom_range(9) == 0)
                send_plain(FUNC_WRITE, 10'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    row_t directed [] = '{
        '{FUNC_WRITE, 10'd0, 32'h0, 32'h0, 32'h0, 1, 32'h0, ST_WRITE},
        '{FUNC_WRITE, 10'd1, 32'h1_0000, 32'h2_0000, 32'h0, 1, 32'h0, ST_WRITE},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h8000_0000, 1, 32'h0, ST_BELOW},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'hffff_ffff, 1, 32'h0, ST_BELOW},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h0, 1, 32'h0, ST_INTERP},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h1_0000, 1, 32'h2_0000, ST_INTERP},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h8000, 0, 32'h0, ST_WRITE},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h7fff_ffff, 0, 32'h0, ST_WRITE},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h1_8000, 0, 32'h0, ST_WRITE},
        '{FUNC_WRITE, 10'd1, 32'h0, 32'h5, 32'h0, 1, 32'h0, ST_WRITE},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h1, 1, 32'h0, ST_ZERO},
        '{FUNC_WRITE, 10'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 1, 32'h0, ST_WRITE},
        '{FUNC_WRITE, 10'd1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 1, 32'h0, ST_WRITE},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h0, 0, 32'h0, ST_WRITE},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h7fff_ffff, 1, 32'h8000_0000, ST_INTERP},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h8000_0000, 1, 32'h7fff_ffff, ST_INTERP},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'h4000_0000, 0, 32'h0, ST_WRITE},
        '{FUNC_WRITE, 10'd1023, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1, 32'h0, ST_WRITE},
        '{FUNC_WRITE, 10'd0, 32'd100, 32'h0, 32'h0, 1, 32'h0, ST_WRITE},
        '{FUNC_WRITE, 10'd1, 32'hffff_ff9c, 32'h3_0000, 32'h0, 1, 32'h0, ST_WRITE},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'd50, 1, 32'h0, ST_BELOW},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'd200, 0, 32'h0, ST_WRITE},
        '{FUNC_QUERY, 10'd0, 32'h0, 32'h0, 32'd100, 1, 32'h0, ST_INTERP}
    };

    initial begin
        int     phase, n, special;
        logic [10:0] cfg;
        count_reg = 11'd2;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[r])
            send(directed[r].func, directed[r].idx, directed[r].x, directed[r].y, directed[r].q,
                 directed[r].typed, '{value: directed[r].value, st: directed[r].st, sat: 1'b0});
        phase = 0;
        while (sent < 180) begin
            case (phase % 5)
                1: begin send_idle = 82; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 82; end
                3: begin send_idle = 23; recv_stall = 23; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            special = $urandom_range(9);
            n = special < 2 ? $urandom_range(2, 3) : $urandom_range(2, 12);
            cfg = (special == 0) ? 11'($urandom_range(0, 1)) : 11'(n);
            write_count(cfg);
            load_table(n < 2 ? 2 : n, $urandom_range(9) != 0);
            repeat ($urandom_range(15, 35))
                send_plain(FUNC_QUERY, 10'($urandom), $urandom, $urandom, pick_query(n));
            phase++;
        end
        send_idle = 0;
        recv_stall = 0;
        write_count(11'd1024);
        load_table(DEPTH, 1'b1);
        repeat (8)
            send_plain(FUNC_QUERY, 10'($urandom), $urandom, $urandom, pick_query(DEPTH));
        write_count(11'h7ff);
        repeat (8)
            send_plain(FUNC_QUERY, 10'($urandom), $urandom, $urandom, pick_query(DEPTH));
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d items over %0d table phases, the largest tables included.",
                 sent, phase);
        $display("Queries by status: interpolated %0d, extrapolated %0d, below %0d, zero-width %0d.",
                 status_seen[ST_INTERP], status_seen[ST_EXTRAP], status_seen[ST_BELOW],
                 status_seen[ST_ZERO]);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
